// ----- sv/vrs_pkg.sv -----
package vrs_pkg;

    localparam int GRID_BITS   = 4;
    localparam int ADDR_W      = 3 * GRID_BITS;
    localparam int CELL_W      = 12;
    localparam int POS_W       = 27;
    localparam int CAM_W       = 24;
    localparam int DIR_W       = 16;
    localparam int AMB_W       = 9;
    localparam int TMAX_W      = 32;
    localparam int QUO_W       = 31;
    localparam int T_W         = 22;
    localparam int BRIGHT_W    = 23;
    localparam int DIV_STEPS   = 31;
    localparam int MAX_DIST    = 32;

    localparam logic [TMAX_W-1:0] DIST_LIMIT  = TMAX_W'(MAX_DIST * 65536);
    localparam logic [TMAX_W-1:0] NEVER       = {TMAX_W{1'b1}};
    localparam logic [QUO_W-1:0]  DELTA_NUM   = QUO_W'(32'h4000_0000);
    localparam logic [31:0]       MISS_COLOR  = 32'h0000_00FF;
    localparam logic [AMB_W-1:0]  AMB_FULL    = AMB_W'(256);
    localparam logic signed [23:0] NUDGE_Q16  = 24'sd66;

    localparam logic [2:0] CFG_CAMERA_X = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y = 3'd1;
    localparam logic [2:0] CFG_CAMERA_Z = 3'd2;
    localparam logic [2:0] CFG_LIGHT_X  = 3'd3;
    localparam logic [2:0] CFG_LIGHT_Y  = 3'd4;
    localparam logic [2:0] CFG_LIGHT_Z  = 3'd5;
    localparam logic [2:0] CFG_AMBIENT  = 3'd6;

    typedef struct packed {
        logic       store;
        logic       load;
        logic       walk_init;
        logic [1:0] axis;
        logic       div_start;
        logic       div_delta;
        logic       div_load_t;
        logic       div_load_d;
        logic       advance;
        logic       save_prim;
        logic       org_mul;
        logic       org_add;
        logic       shad_set;
        logic       shade;
        logic       finish;
        logic       finish_miss;
    } vrs_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       dist_over;
        logic       cell_hit;
        logic [2:0] axis_zero;
    } vrs_status_t;

endpackage

// ----- sv/vrs_div.sv -----
module vrs_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [vrs_pkg::QUO_W-1:0]  dividend,
    input  logic [vrs_pkg::DIR_W-1:0]  divisor,
    output logic [vrs_pkg::QUO_W-1:0]  quotient,
    output logic                       done
);

    logic [4:0]                  cnt_reg;
    logic                        done_reg;
    logic [vrs_pkg::QUO_W-1:0]   q_reg;
    logic [vrs_pkg::DIR_W-1:0]   rem_reg;
    logic [vrs_pkg::DIR_W:0]     trial;
    logic                        ge;
    logic [vrs_pkg::DIR_W-1:0]   rem_next;

    always_comb
    begin
        trial    = {rem_reg, q_reg[vrs_pkg::QUO_W-1]};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? vrs_pkg::DIR_W'(trial - {1'b0, divisor}) : trial[vrs_pkg::DIR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 5'(vrs_pkg::DIV_STEPS);
            end
            else if (cnt_reg != 5'd0)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != 5'd0)
        begin
            q_reg   <= {q_reg[vrs_pkg::QUO_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ----- sv/vrs_dp.sv -----
module vrs_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  vrs_pkg::vrs_cmd_t      cmd,
    output vrs_pkg::vrs_status_t   status,
    input  logic                   wr_en,
    input  logic [2:0]             wr_index,
    input  logic [23:0]            wr_data,
    input  logic [11:0]            voxel_address,
    input  logic                   voxel_solid,
    input  logic [7:0]             voxel_red,
    input  logic [7:0]             voxel_green,
    input  logic [7:0]             voxel_blue,
    input  logic [7:0]             voxel_alpha,
    input  logic signed [15:0]     ray_dir_x,
    input  logic signed [15:0]     ray_dir_y,
    input  logic signed [15:0]     ray_dir_z,
    output logic [31:0]            pixel_color,
    output logic                   ray_hit,
    output logic                   in_shadow,
    output logic                   done
);

    localparam int DW = vrs_pkg::DIR_W;
    localparam int PW = vrs_pkg::POS_W;
    localparam int CW = vrs_pkg::CELL_W;
    localparam int GB = vrs_pkg::GRID_BITS;

    logic signed [vrs_pkg::CAM_W-1:0] cam_reg [3];
    logic signed [DW-1:0]             lig_reg [3];
    logic [vrs_pkg::AMB_W-1:0]        amb_reg;
    logic signed [DW-1:0]             dir_reg [3];
    logic signed [PW-1:0]             org_reg [3];
    logic signed [CW-1:0]             cell_reg [3];
    logic [vrs_pkg::TMAX_W-1:0]       tmax_reg [3];
    logic [vrs_pkg::QUO_W-1:0]        delta_reg [3];
    logic [vrs_pkg::TMAX_W-1:0]       dist_reg;
    logic [1:0]                       norm_axis_reg;
    logic                             norm_valid_reg;
    logic                             shadow_reg;
    logic [vrs_pkg::T_W-1:0]          t_reg;
    logic [1:0]                       pn_axis_reg;
    logic                             pn_valid_reg;
    logic [31:0]                      rgba_reg;
    logic                             shad_hit_reg;
    logic signed [38:0]               prod_reg;
    logic [vrs_pkg::BRIGHT_W-1:0]     bright_reg;
    logic [32:0]                      rd_reg;
    logic [31:0]                      pixel_reg;
    logic                             hit_reg;
    logic                             in_shadow_reg;
    logic                             done_reg;

    logic [32:0]                      mem [1 << vrs_pkg::ADDR_W];

    logic signed [DW-1:0]             wdir [3];
    logic signed [DW-1:0]             d_sel;
    logic signed [PW-1:0]             o_sel;
    logic [16:0]                      num;
    logic [DW-1:0]                    mag;
    logic [vrs_pkg::QUO_W-1:0]        dividend;
    logic [vrs_pkg::QUO_W-1:0]        quotient;
    logic                             div_done;
    logic [1:0]                       sel_axis;
    logic                             in_grid;
    logic [vrs_pkg::ADDR_W-1:0]       raddr;
    logic signed [23:0]               nud_prod;
    logic signed [PW-1:0]             org_next;
    logic signed [DW:0]               dot_raw;
    logic [14:0]                      dotp;
    logic [vrs_pkg::AMB_W-1:0]        amb_sat;
    logic [vrs_pkg::BRIGHT_W-1:0]     bright_next;
    logic [7:0]                       chan [3];

    vrs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (mag),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            wdir[a] = shadow_reg ? lig_reg[a] : dir_reg[a];
        end
        d_sel    = wdir[cmd.axis];
        o_sel    = org_reg[cmd.axis];
        num      = d_sel[DW-1] ? {1'b0, o_sel[15:0]} : 17'd65536 - {1'b0, o_sel[15:0]};
        mag      = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
        dividend = cmd.div_delta ? vrs_pkg::DELTA_NUM : {num, 14'b0};

        // x only if strictly smallest, then y if below z, else z
        if (tmax_reg[0] < tmax_reg[1] && tmax_reg[0] < tmax_reg[2])
            sel_axis = 2'd0;
        else if (tmax_reg[1] < tmax_reg[2])
            sel_axis = 2'd1;
        else
            sel_axis = 2'd2;

        in_grid = (cell_reg[0][CW-1:GB] == '0) && (cell_reg[1][CW-1:GB] == '0)
               && (cell_reg[2][CW-1:GB] == '0);
        raddr   = {cell_reg[2][GB-1:0], cell_reg[1][GB-1:0], cell_reg[0][GB-1:0]};

        nud_prod = 24'(lig_reg[cmd.axis]) * vrs_pkg::NUDGE_Q16;
        org_next = PW'(cam_reg[cmd.axis]) + PW'(prod_reg >>> 14) + PW'(nud_prod >>> 14);

        // light against the face normal, which points against the step
        dot_raw = dir_reg[pn_axis_reg] > 0 ? -(DW+1)'(lig_reg[pn_axis_reg])
                                          : (DW+1)'(lig_reg[pn_axis_reg]);
        if (shad_hit_reg || !pn_valid_reg || dot_raw < 0)
            dotp = '0;
        else if (dot_raw > 17'sd16384)
            dotp = 15'd16384;
        else
            dotp = dot_raw[14:0];
        amb_sat     = amb_reg > vrs_pkg::AMB_FULL ? vrs_pkg::AMB_FULL : amb_reg;
        bright_next = vrs_pkg::BRIGHT_W'({amb_sat, 14'b0})
                    + vrs_pkg::BRIGHT_W'(vrs_pkg::AMB_FULL - amb_sat)
                    * vrs_pkg::BRIGHT_W'(dotp);

        for (int c = 0; c < 3; c++)
        begin
            chan[c] = 8'((30'(rgba_reg[31 - 8*c -: 8]) * 30'(bright_reg)) >> 22);
        end

        status.div_done  = div_done;
        status.dist_over = dist_reg >= vrs_pkg::DIST_LIMIT;
        status.cell_hit  = in_grid && rd_reg[32];
        for (int a = 0; a < 3; a++)
        begin
            status.axis_zero[a] = wdir[a] == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[voxel_address[vrs_pkg::ADDR_W-1:0]] <=
                {voxel_solid, voxel_red, voxel_green, voxel_blue, voxel_alpha};
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg[0] <= 24'sd524288;
            cam_reg[1] <= 24'sd1048576;
            cam_reg[2] <= 24'sd524288;
            lig_reg[0] <= -16'sd13136;
            lig_reg[1] <= 16'sd8758;
            lig_reg[2] <= -16'sd4379;
            amb_reg    <= 9'd128;
        end
        else if (wr_en)
        begin
            case (wr_index)
                vrs_pkg::CFG_CAMERA_X: cam_reg[0] <= wr_data;
                vrs_pkg::CFG_CAMERA_Y: cam_reg[1] <= wr_data;
                vrs_pkg::CFG_CAMERA_Z: cam_reg[2] <= wr_data;
                vrs_pkg::CFG_LIGHT_X:  lig_reg[0] <= wr_data[15:0];
                vrs_pkg::CFG_LIGHT_Y:  lig_reg[1] <= wr_data[15:0];
                vrs_pkg::CFG_LIGHT_Z:  lig_reg[2] <= wr_data[15:0];
                vrs_pkg::CFG_AMBIENT:  amb_reg    <= wr_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish || cmd.finish_miss;
            if (cmd.load)
                shadow_reg <= 1'b0;
            else if (cmd.save_prim)
                shadow_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dir_reg[0] <= ray_dir_x;
            dir_reg[1] <= ray_dir_y;
            dir_reg[2] <= ray_dir_z;
            for (int a = 0; a < 3; a++)
            begin
                org_reg[a] <= PW'(cam_reg[a]);
            end
        end
        if (cmd.walk_init)
        begin
            dist_reg       <= '0;
            norm_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a] <= CW'(org_reg[a] >>> 16);
                if (wdir[a] == '0)
                begin
                    tmax_reg[a]  <= vrs_pkg::NEVER;
                    delta_reg[a] <= '0;
                end
            end
        end
        if (cmd.div_load_t)
            tmax_reg[cmd.axis] <= vrs_pkg::TMAX_W'(quotient);
        if (cmd.div_load_d)
            delta_reg[cmd.axis] <= quotient;
        if (cmd.advance)
        begin
            if (wdir[sel_axis] != '0)
                cell_reg[sel_axis] <= wdir[sel_axis][DW-1] ? cell_reg[sel_axis] - 12'sd1
                                                          : cell_reg[sel_axis] + 12'sd1;
            dist_reg           <= tmax_reg[sel_axis];
            tmax_reg[sel_axis] <= tmax_reg[sel_axis] + vrs_pkg::TMAX_W'(delta_reg[sel_axis]);
            norm_axis_reg      <= sel_axis;
            norm_valid_reg     <= 1'b1;
        end
        if (cmd.save_prim)
        begin
            t_reg        <= dist_reg[vrs_pkg::T_W-1:0];
            pn_axis_reg  <= norm_axis_reg;
            pn_valid_reg <= norm_valid_reg;
            rgba_reg     <= rd_reg[31:0];
            shad_hit_reg <= 1'b0;
        end
        if (cmd.org_mul)
            prod_reg <= dir_reg[cmd.axis] * $signed({1'b0, t_reg});
        if (cmd.org_add)
            org_reg[cmd.axis] <= org_next;
        if (cmd.shad_set)
            shad_hit_reg <= 1'b1;
        if (cmd.shade)
            bright_reg <= bright_next;
        if (cmd.finish)
        begin
            pixel_reg     <= {chan[0], chan[1], chan[2], rgba_reg[7:0]};
            hit_reg       <= 1'b1;
            in_shadow_reg <= shad_hit_reg;
        end
        else if (cmd.finish_miss)
        begin
            pixel_reg     <= vrs_pkg::MISS_COLOR;
            hit_reg       <= 1'b0;
            in_shadow_reg <= 1'b0;
        end
    end

    assign pixel_color = pixel_reg;
    assign ray_hit     = hit_reg;
    assign in_shadow   = in_shadow_reg;
    assign done        = done_reg;

endmodule

// ----- sv/vrs_ctrl.sv -----
module vrs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  operation,
    input  vrs_pkg::vrs_status_t  status,
    output vrs_pkg::vrs_cmd_t     cmd,
    output logic                  busy
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INIT    = 4'd1;
    localparam logic [3:0] ST_AXIS    = 4'd2;
    localparam logic [3:0] ST_WAIT_T  = 4'd3;
    localparam logic [3:0] ST_WAIT_D  = 4'd4;
    localparam logic [3:0] ST_LOOKUP  = 4'd5;
    localparam logic [3:0] ST_TEST    = 4'd6;
    localparam logic [3:0] ST_ORG_MUL = 4'd7;
    localparam logic [3:0] ST_ORG_ADD = 4'd8;
    localparam logic [3:0] ST_SHADE   = 4'd9;
    localparam logic [3:0] ST_COLOR   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation)
                    begin
                        cmd.load   = 1'b1;
                        phase_next = 1'b0;
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.walk_init = 1'b1;
                axis_next     = 2'd0;
                state_next    = ST_AXIS;
            end
            ST_AXIS:
            begin
                if (status.axis_zero[axis_reg])
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? ST_LOOKUP : ST_AXIS;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_WAIT_T;
                end
            end
            ST_WAIT_T:
            begin
                if (status.div_done)
                begin
                    cmd.div_load_t = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_delta  = 1'b1;
                    state_next     = ST_WAIT_D;
                end
            end
            ST_WAIT_D:
            begin
                if (status.div_done)
                begin
                    cmd.div_load_d = 1'b1;
                    axis_next      = axis_reg + 2'd1;
                    state_next     = (axis_reg == 2'd2) ? ST_LOOKUP : ST_AXIS;
                end
            end
            ST_LOOKUP:
            begin
                if (status.dist_over)
                begin
                    if (phase_reg)
                    begin
                        state_next = ST_SHADE;
                    end
                    else
                    begin
                        cmd.finish_miss = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.cell_hit)
                begin
                    if (phase_reg)
                    begin
                        cmd.shad_set = 1'b1;
                        state_next   = ST_SHADE;
                    end
                    else
                    begin
                        cmd.save_prim = 1'b1;
                        phase_next    = 1'b1;
                        axis_next     = 2'd0;
                        state_next    = ST_ORG_MUL;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_ORG_MUL:
            begin
                cmd.org_mul = 1'b1;
                state_next  = ST_ORG_ADD;
            end
            ST_ORG_ADD:
            begin
                cmd.org_add = 1'b1;
                axis_next   = axis_reg + 2'd1;
                state_next  = (axis_reg == 2'd2) ? ST_INIT : ST_ORG_MUL;
            end
            ST_SHADE:
            begin
                cmd.shade  = 1'b1;
                state_next = ST_COLOR;
            end
            ST_COLOR:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;
        end
    end

    assign busy = state_reg != ST_IDLE;

endmodule

// ----- sv/voxel_ray_shade_top.sv -----
// Voxel ray shader: walks a 16x16x16 voxel grid cell by cell along one ray.
// Input: pulse start with busy low. operation=0 stores one voxel word at
// voxel_address in that same cycle (no result, busy stays low). operation=1
// traces ray_dir_x/y/z from the camera and returns one result word.
// Result: done is high for exactly one cycle with pixel_color, ray_hit and
// in_shadow valid; the receiver cannot stall and must take it then.
// Config: wr_en/wr_index/wr_data write camera, light and ambient registers;
// write only while busy is low and no result is pending.
// Trace: each walk first runs up to six divisions (first crossing and
// step per nonzero axis), then visits cells one by one, each through a
// lookup and a test state, since each cell reads the voxel RAM with one
// registered read. A hit adds a multiply and an add per axis for the shadow
// origin, a second walk of the same form, and a shade and a color step.
// Busy stays high throughout, one trace at a time.
// Reset clears the control and loads default camera, light and ambient;
// the voxel RAM is not cleared and must be written before tracing.
module voxel_ray_shade_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [11:0]        voxel_address,
    input  logic               voxel_solid,
    input  logic [7:0]         voxel_red,
    input  logic [7:0]         voxel_green,
    input  logic [7:0]         voxel_blue,
    input  logic [7:0]         voxel_alpha,
    input  logic signed [15:0] ray_dir_x,
    input  logic signed [15:0] ray_dir_y,
    input  logic signed [15:0] ray_dir_z,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [23:0]        wr_data,
    output logic [31:0]        pixel_color,
    output logic               ray_hit,
    output logic               in_shadow,
    output logic               done
);

    vrs_pkg::vrs_cmd_t    cmd;
    vrs_pkg::vrs_status_t status;

    vrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    vrs_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .voxel_address (voxel_address),
        .voxel_solid   (voxel_solid),
        .voxel_red     (voxel_red),
        .voxel_green   (voxel_green),
        .voxel_blue    (voxel_blue),
        .voxel_alpha   (voxel_alpha),
        .ray_dir_x     (ray_dir_x),
        .ray_dir_y     (ray_dir_y),
        .ray_dir_z     (ray_dir_z),
        .pixel_color   (pixel_color),
        .ray_hit       (ray_hit),
        .in_shadow     (in_shadow),
        .done          (done)
    );

endmodule
